[sv/scro_pkg.sv]
// Shared types, codes and constants for the sequence-checked record outbox.
package scro_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int DEFAULT_RECORD_BITS = 64;

  localparam int SESSION_BITS  = 64;
  localparam int SEQ_BITS      = 32;
  localparam int PAYLOAD_BITS  = 64;
  localparam int COUNTER_BITS  = 32;
  localparam int NUM_COUNTERS  = 7;
  localparam int SELECT_BITS   = 3;
  localparam int ERROR_BITS    = 3;

  localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;
  localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);

  typedef enum logic [1:0] {
    MODE_ENQUEUE = 2'd0,
    MODE_COMMIT  = 2'd1,
    MODE_DISCARD = 2'd2,
    MODE_STATUS  = 2'd3
  } mode_t;

  typedef enum logic [ERROR_BITS-1:0] {
    ERR_NONE      = 3'd0,
    ERR_INVALID   = 3'd1,
    ERR_DUPLICATE = 3'd2,
    ERR_ORDER     = 3'd3,
    ERR_FULL      = 3'd4,
    ERR_MISMATCH  = 3'd5
  } error_t;

  typedef enum logic [SELECT_BITS-1:0] {
    CNT_ACCEPTED  = 3'd0,
    CNT_INVALID   = 3'd1,
    CNT_DUPLICATE = 3'd2,
    CNT_ORDER     = 3'd3,
    CNT_FULL      = 3'd4,
    CNT_COMMITTED = 3'd5,
    CNT_DISCARDED = 3'd6
  } counter_id_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_PUBLISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic publish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
  } status_t;

endpackage

[sv/scro_ctrl.sv]
// Controller state machine: sequences capture, check/update, front fetch and publish.
module scro_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  scro_pkg::status_t status_i,
  output scro_pkg::cmd_t    cmd_o
);

  scro_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scro_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    cmd_o         = '0;
    unique case (state)
      scro_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_next    = scro_pkg::ST_CHECK;
        end
      end
      scro_pkg::ST_CHECK: begin
        cmd_o.execute = 1'b1;
        state_next    = scro_pkg::ST_FETCH;
      end
      // wait here while the registered read fetches the front entry at the new head
      scro_pkg::ST_FETCH: begin
        state_next = scro_pkg::ST_PUBLISH;
      end
      scro_pkg::ST_PUBLISH: begin
        if (status_i.slot_free) begin
          cmd_o.publish = 1'b1;
          state_next    = scro_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = scro_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/scro_datapath.sv]
// Datapath: entry memory, ring pointers, sequence checks, event counters, output register.
module scro_datapath #(
  parameter int QUEUE_DEPTH = scro_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int RECORD_BITS = scro_pkg::DEFAULT_RECORD_BITS,
  localparam int CntW       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  scro_pkg::cmd_t                     cmd_i,
  output scro_pkg::status_t                  status_o,
  input  logic [1:0]                         mode,
  input  logic                               record_ok,
  input  logic [scro_pkg::SESSION_BITS-1:0]  record_session,
  input  logic [scro_pkg::SEQ_BITS-1:0]      sequence_req,
  input  logic [scro_pkg::PAYLOAD_BITS-1:0]  payload,
  input  logic [scro_pkg::SELECT_BITS-1:0]   counter_select,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [scro_pkg::ERROR_BITS-1:0]    error_code,
  output logic [CntW-1:0]                    queued_count,
  output logic                               front_valid,
  output logic [scro_pkg::SESSION_BITS-1:0]  front_session,
  output logic [scro_pkg::SEQ_BITS-1:0]      front_sequence,
  output logic [RECORD_BITS-1:0]             front_payload,
  output logic [CntW-1:0]                    discarded_now,
  output logic                               prior_seen,
  output logic [scro_pkg::SESSION_BITS-1:0]  last_session,
  output logic [scro_pkg::SEQ_BITS-1:0]      last_seq,
  output logic [scro_pkg::COUNTER_BITS-1:0]  counter_value
);

  localparam int IdxBits   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int EntryBits = scro_pkg::SESSION_BITS + scro_pkg::SEQ_BITS + RECORD_BITS;
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0]    FullCnt = CntW'(QUEUE_DEPTH);
  localparam int CW = scro_pkg::COUNTER_BITS;
  localparam logic [scro_pkg::SELECT_BITS-1:0] SELECT_LIMIT =
    scro_pkg::SELECT_BITS'(scro_pkg::NUM_COUNTERS);

  // captured transaction
  scro_pkg::mode_t                      mode_q;
  logic                                 ok_q;
  logic [scro_pkg::SESSION_BITS-1:0]    sess_q;
  logic [scro_pkg::SEQ_BITS-1:0]        seq_q;
  logic [RECORD_BITS-1:0]               data_q;
  logic [scro_pkg::SELECT_BITS-1:0]     sel_q;

  // queue state
  logic [EntryBits-1:0] mem [QUEUE_DEPTH];
  logic [EntryBits-1:0] rd_q;
  logic [IdxBits-1:0]   head, tail;
  logic [CntW-1:0]      count;
  logic                 prior_flag;
  logic [scro_pkg::SESSION_BITS-1:0] last_session_reg;
  logic [scro_pkg::SEQ_BITS-1:0]     last_sequence_reg;
  logic [CW-1:0]        counters [scro_pkg::NUM_COUNTERS];

  // results of the current transaction
  scro_pkg::error_t     err_q;
  logic [CntW-1:0]      dropped_q;

  // check logic
  logic [scro_pkg::SESSION_BITS-1:0] rd_session;
  logic [scro_pkg::SEQ_BITS-1:0]     rd_sequence;
  logic [RECORD_BITS-1:0]            rd_payload;
  logic                              same_session, dup, ordered, full, commit_ok;
  scro_pkg::error_t                  err;
  logic                              push, pop, drop;
  logic [scro_pkg::NUM_COUNTERS-1:0] bump_en;
  logic [CW-1:0]                     bump_amt;

  assign {rd_session, rd_sequence, rd_payload} = rd_q;

  assign status_o.slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      mode_q <= scro_pkg::mode_t'(mode);
      ok_q   <= record_ok;
      sess_q <= record_session;
      seq_q  <= sequence_req;
      data_q <= payload[RECORD_BITS-1:0];
      sel_q  <= counter_select;
    end
  end

  assign same_session = sess_q == last_session_reg;
  assign dup          = prior_flag && same_session && (seq_q == last_sequence_reg);
  assign full         = count == FullCnt;
  assign commit_ok    = (count != '0) && (sess_q != '0) && (seq_q != '0) &&
                        (rd_session == sess_q) && (rd_sequence == seq_q);

  always_comb begin
    if (!prior_flag) begin
      ordered = seq_q == scro_pkg::SEQ_ONE;
    end else if (same_session) begin
      ordered = (last_sequence_reg != scro_pkg::SEQ_MAX) &&
                (seq_q == last_sequence_reg + scro_pkg::SEQ_ONE);
    end else begin
      ordered = (sess_q > last_session_reg) && (seq_q == scro_pkg::SEQ_ONE);
    end
  end

  always_comb begin
    err      = scro_pkg::ERR_NONE;
    push     = 1'b0;
    pop      = 1'b0;
    drop     = 1'b0;
    bump_en  = '0;
    unique case (mode_q)
      scro_pkg::MODE_ENQUEUE: begin
        if (!ok_q) begin
          err = scro_pkg::ERR_INVALID;
          bump_en[scro_pkg::CNT_INVALID] = 1'b1;
        end else if (dup) begin
          err = scro_pkg::ERR_DUPLICATE;
          bump_en[scro_pkg::CNT_DUPLICATE] = 1'b1;
        end else if (!ordered) begin
          err = scro_pkg::ERR_ORDER;
          bump_en[scro_pkg::CNT_ORDER] = 1'b1;
        end else if (full) begin
          err = scro_pkg::ERR_FULL;
          bump_en[scro_pkg::CNT_FULL] = 1'b1;
        end else begin
          push = 1'b1;
          bump_en[scro_pkg::CNT_ACCEPTED] = 1'b1;
        end
      end
      scro_pkg::MODE_COMMIT: begin
        if (commit_ok) begin
          pop = 1'b1;
          bump_en[scro_pkg::CNT_COMMITTED] = 1'b1;
        end else begin
          err = scro_pkg::ERR_MISMATCH;
        end
      end
      scro_pkg::MODE_DISCARD: begin
        drop = 1'b1;
        bump_en[scro_pkg::CNT_DISCARDED] = 1'b1;
      end
      scro_pkg::MODE_STATUS: begin
      end
      default: begin
      end
    endcase
    bump_amt = drop ? CW'(count) : CW'(1);
  end

  // entry memory: one write port at tail, registered read at head
  always_ff @(posedge clk) begin
    if (cmd_i.execute && push) begin
      mem[tail] <= {sess_q, seq_q, data_q};
    end
    rd_q <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head              <= '0;
      tail              <= '0;
      count             <= '0;
      prior_flag        <= 1'b0;
      last_session_reg  <= '0;
      last_sequence_reg <= '0;
    end else if (cmd_i.execute) begin
      if (push) begin
        tail              <= (tail == LastIdx) ? '0 : tail + 1'b1;
        count             <= count + 1'b1;
        prior_flag        <= 1'b1;
        last_session_reg  <= sess_q;
        last_sequence_reg <= seq_q;
      end
      if (pop) begin
        head  <= (head == LastIdx) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
      if (drop) begin
        head  <= tail;
        count <= '0;
      end
    end
  end

  // saturating event counters, one adder each
  for (genvar i = 0; i < scro_pkg::NUM_COUNTERS; i++) begin : g_cnt
    logic [CW:0] sum;
    assign sum = {1'b0, counters[i]} + {1'b0, bump_amt};
    always_ff @(posedge clk) begin
      if (rst) begin
        counters[i] <= '0;
      end else if (cmd_i.execute && bump_en[i]) begin
        counters[i] <= sum[CW] ? '1 : sum[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.execute) begin
      err_q     <= err;
      dropped_q <= drop ? count : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.publish) begin
      error_code     <= err_q;
      queued_count   <= count;
      front_valid    <= count != '0;
      front_session  <= (count != '0) ? rd_session  : '0;
      front_sequence <= (count != '0) ? rd_sequence : '0;
      front_payload  <= (count != '0) ? rd_payload  : '0;
      discarded_now  <= dropped_q;
      prior_seen     <= prior_flag;
      last_session   <= last_session_reg;
      last_seq       <= last_sequence_reg;
      counter_value  <= (sel_q < SELECT_LIMIT) ? counters[sel_q] : '0;
    end
  end

  a_empty_ring: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("empty queue with head and tail apart");

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd_i.publish |-> (!out_valid || !out_stall))
    else $error("result published over a pending transaction");

  a_reject_holds_tail: assert property (@(posedge clk) disable iff (rst)
    (cmd_i.execute && err != scro_pkg::ERR_NONE) |=> $stable(tail) && $stable(count))
    else $error("rejected transaction changed the queue");

  a_prior_sticky: assert property (@(posedge clk) disable iff (rst)
    prior_flag |=> prior_flag)
    else $error("prior flag dropped");

endmodule

[sv/sequence_checked_record_outbox.sv]
// Top level of the sequence-checked record outbox.
// A ring queue of QUEUE_DEPTH records (session, sequence, RECORD_BITS payload) that
// checks each enqueue for decode status, duplication, sequence order and fullness,
// pops the front on a matching commit, and can drop all entries at once; seven
// saturating 32-bit event counters are read back through counter_select. Each
// transaction passes the idle (capture), check, fetch and publish states, the result
// register loading in the publish state, and the next transaction is accepted only
// back in idle, so transactions never overlap: the entry memory's registered read port
// fetches the front for the commit check and then the new front after the pointer
// update. The next input is taken while a result still waits in the output register;
// a result that cannot load because the previous one is still stalled holds the
// block until the output register frees. No clearing pass follows reset; the entry
// memory is only ever read below the fill count.
module sequence_checked_record_outbox #(
  parameter int QUEUE_DEPTH = scro_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int RECORD_BITS = scro_pkg::DEFAULT_RECORD_BITS,
  localparam int CntW       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         mode,
  input  logic                               record_ok,
  input  logic [scro_pkg::SESSION_BITS-1:0]  record_session,
  input  logic [scro_pkg::SEQ_BITS-1:0]      sequence_req,
  input  logic [scro_pkg::PAYLOAD_BITS-1:0]  payload,
  input  logic [scro_pkg::SELECT_BITS-1:0]   counter_select,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [scro_pkg::ERROR_BITS-1:0]    error_code,
  output logic [CntW-1:0]                    queued_count,
  output logic                               front_valid,
  output logic [scro_pkg::SESSION_BITS-1:0]  front_session,
  output logic [scro_pkg::SEQ_BITS-1:0]      front_sequence,
  output logic [RECORD_BITS-1:0]             front_payload,
  output logic [CntW-1:0]                    discarded_now,
  output logic                               prior_seen,
  output logic [scro_pkg::SESSION_BITS-1:0]  last_session,
  output logic [scro_pkg::SEQ_BITS-1:0]      last_seq,
  output logic [scro_pkg::COUNTER_BITS-1:0]  counter_value
);

  scro_pkg::cmd_t    cmd;
  scro_pkg::status_t status;

  scro_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status_i (status),
    .cmd_o    (cmd)
  );

  scro_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .RECORD_BITS (RECORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode           (mode),
    .record_ok      (record_ok),
    .record_session (record_session),
    .sequence_req   (sequence_req),
    .payload        (payload),
    .counter_select (counter_select),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .error_code     (error_code),
    .queued_count   (queued_count),
    .front_valid    (front_valid),
    .front_session  (front_session),
    .front_sequence (front_sequence),
    .front_payload  (front_payload),
    .discarded_now  (discarded_now),
    .prior_seen     (prior_seen),
    .last_session   (last_session),
    .last_seq       (last_seq),
    .counter_value  (counter_value)
  );

endmodule

[tb/sv/sequence_checked_record_outbox_tb.sv]
// Self-checking testbench for the sequence-checked record outbox.
`timescale 1ns / 1ps

module sequence_checked_record_outbox_tb;
  import scro_pkg::*;

  localparam int DEPTH        = DEFAULT_QUEUE_DEPTH;
  localparam int REC_BITS     = DEFAULT_RECORD_BITS;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = 20;
  localparam logic [SELECT_BITS-1:0] SEL_UNUSED = 3'd7;
  localparam logic [63:0] RECORD_MASK = {64{1'b1}} >> (64 - REC_BITS);

  typedef struct packed {
    mode_t                   op;
    logic                    ok;
    logic [SESSION_BITS-1:0] sess;
    logic [SEQ_BITS-1:0]     seq;
    logic [PAYLOAD_BITS-1:0] data;
    logic [SELECT_BITS-1:0]  sel;
  } record_item_t;

  typedef struct packed {
    error_t                  err;
    logic [CNT_W-1:0]        fill;
    logic                    fvalid;
    logic [SESSION_BITS-1:0] fsess;
    logic [SEQ_BITS-1:0]     fseq;
    logic [REC_BITS-1:0]     fdata;
    logic [CNT_W-1:0]        dropped;
    logic                    prior;
    logic [SESSION_BITS-1:0] lsess;
    logic [SEQ_BITS-1:0]     lseq;
    logic [COUNTER_BITS-1:0] cval;
  } outbox_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_STATUS;
  logic record_ok = 1'b0;
  logic [SESSION_BITS-1:0] record_session = '0;
  logic [SEQ_BITS-1:0] sequence_req = '0;
  logic [PAYLOAD_BITS-1:0] payload = '0;
  logic [SELECT_BITS-1:0] counter_select = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ERROR_BITS-1:0] error_code;
  logic [CNT_W-1:0] queued_count;
  logic front_valid;
  logic [SESSION_BITS-1:0] front_session;
  logic [SEQ_BITS-1:0] front_sequence;
  logic [REC_BITS-1:0] front_payload;
  logic [CNT_W-1:0] discarded_now;
  logic prior_seen;
  logic [SESSION_BITS-1:0] last_session;
  logic [SEQ_BITS-1:0] last_seq;
  logic [COUNTER_BITS-1:0] counter_value;

  // Shadow copy of the outbox state
  logic [SESSION_BITS-1:0] ring_sess [DEPTH];
  logic [SEQ_BITS-1:0]     ring_seq  [DEPTH];
  logic [REC_BITS-1:0]     ring_data [DEPTH];
  logic [3:0]              head_r = '0;
  logic [3:0]              tail_r = '0;
  logic [CNT_W-1:0]        fill_r = '0;
  logic                    prior_r = 1'b0;
  logic [SESSION_BITS-1:0] last_sess_r = '0;
  logic [SEQ_BITS-1:0]     last_seq_r = '0;
  logic [COUNTER_BITS-1:0] event_cnt [NUM_COUNTERS];

  outbox_status_t pending_status[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;

  sequence_checked_record_outbox #(
    .QUEUE_DEPTH(DEPTH),
    .RECORD_BITS(REC_BITS)
  ) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .record_ok(record_ok), .record_session(record_session),
    .sequence_req(sequence_req), .payload(payload), .counter_select(counter_select),
    .out_valid(out_valid), .out_stall(out_stall),
    .error_code(error_code), .queued_count(queued_count), .front_valid(front_valid),
    .front_session(front_session), .front_sequence(front_sequence),
    .front_payload(front_payload), .discarded_now(discarded_now),
    .prior_seen(prior_seen), .last_session(last_session), .last_seq(last_seq),
    .counter_value(counter_value)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_status.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void bump_counter(counter_id_t id, logic [COUNTER_BITS-1:0] amount);
    if (amount > SEQ_MAX - event_cnt[id]) event_cnt[id] = SEQ_MAX;
    else event_cnt[id] = event_cnt[id] + amount;
  endfunction

  function automatic error_t try_enqueue(record_item_t it);
    logic ordered;
    if (!it.ok) begin
      bump_counter(CNT_INVALID, 1);
      return ERR_INVALID;
    end
    if (prior_r && it.sess == last_sess_r && it.seq == last_seq_r) begin
      bump_counter(CNT_DUPLICATE, 1);
      return ERR_DUPLICATE;
    end
    if (!prior_r) ordered = (it.seq == SEQ_ONE);
    else if (it.sess == last_sess_r)
      ordered = (last_seq_r != SEQ_MAX) && (it.seq == last_seq_r + SEQ_ONE);
    else ordered = (it.sess > last_sess_r) && (it.seq == SEQ_ONE);
    if (!ordered) begin
      bump_counter(CNT_ORDER, 1);
      return ERR_ORDER;
    end
    if (fill_r >= DEPTH) begin
      bump_counter(CNT_FULL, 1);
      return ERR_FULL;
    end
    ring_data[tail_r] = REC_BITS'(it.data & RECORD_MASK);
    ring_sess[tail_r] = it.sess;
    ring_seq[tail_r]  = it.seq;
    tail_r = tail_r + 4'd1;
    fill_r = fill_r + 1'b1;
    prior_r = 1'b1;
    last_sess_r = it.sess;
    last_seq_r = it.seq;
    bump_counter(CNT_ACCEPTED, 1);
    return ERR_NONE;
  endfunction

  // Advance the shadow state by one transaction and return what the block should report
  function automatic outbox_status_t predict_outbox(record_item_t it);
    outbox_status_t s;
    s = '0;
    s.err = ERR_NONE;
    case (it.op)
      MODE_ENQUEUE: s.err = try_enqueue(it);
      MODE_COMMIT: begin
        if (fill_r == 0 || it.sess == 0 || it.seq == 0 ||
            ring_sess[head_r] != it.sess || ring_seq[head_r] != it.seq) begin
          s.err = ERR_MISMATCH;
        end else begin
          head_r = head_r + 4'd1;
          fill_r = fill_r - 1'b1;
          bump_counter(CNT_COMMITTED, 1);
        end
      end
      MODE_DISCARD: begin
        s.dropped = fill_r;
        head_r = tail_r;
        fill_r = '0;
        bump_counter(CNT_DISCARDED, COUNTER_BITS'(s.dropped));
      end
      default: ;
    endcase
    s.fill = fill_r;
    if (fill_r != 0) begin
      s.fvalid = 1'b1;
      s.fsess = ring_sess[head_r];
      s.fseq = ring_seq[head_r];
      s.fdata = ring_data[head_r];
    end
    s.prior = prior_r;
    s.lsess = last_sess_r;
    s.lseq = last_seq_r;
    s.cval = (it.sel < NUM_COUNTERS) ? event_cnt[it.sel] : '0;
    return s;
  endfunction

  function automatic record_item_t make_item(mode_t op, logic ok, logic [SESSION_BITS-1:0] sess,
                                             logic [SEQ_BITS-1:0] seq,
                                             logic [PAYLOAD_BITS-1:0] data,
                                             logic [SELECT_BITS-1:0] sel);
    record_item_t it;
    it.op = op;
    it.ok = ok;
    it.sess = sess;
    it.seq = seq;
    it.data = data;
    it.sel = sel;
    return it;
  endfunction

  // Offer one transaction, hold it through stalls, predict on acceptance
  task automatic send_item(record_item_t it);
    int gap;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode = it.op;
    record_ok = it.ok;
    record_session = it.sess;
    sequence_req = it.seq;
    payload = it.data;
    counter_select = it.sel;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_status.push_back(predict_outbox(it));
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("cycle %0d: %s expected %h, got %h", cycle_count, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    outbox_status_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("cycle %0d: result with nothing expected", cycle_count);
      end else begin
        want = pending_status.pop_front();
        check_field("error_code", error_code, want.err);
        check_field("queued_count", queued_count, want.fill);
        check_field("front_valid", front_valid, want.fvalid);
        check_field("front_session", front_session, want.fsess);
        check_field("front_sequence", front_sequence, want.fseq);
        check_field("front_payload", front_payload, want.fdata);
        check_field("discarded_now", discarded_now, want.dropped);
        check_field("prior_seen", prior_seen, want.prior);
        check_field("last_session", last_session, want.lsess);
        check_field("last_seq", last_seq, want.lseq);
        check_field("counter_value", counter_value, want.cval);
      end
    end
  end

  // Output backpressure
  initial begin
    int n;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      repeat ($urandom_range(0, 12)) @(negedge clk);
      n = quiet ? 0 : pick_gap();
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Well-formed record: next sequence in the session, or sequence one in a larger session
  function automatic record_item_t next_record();
    record_item_t it;
    logic [SESSION_BITS-1:0] jump;
    jump = 64'd1 + ({$urandom, $urandom} >> $urandom_range(24, 63));
    it = make_item(MODE_ENQUEUE, 1'b1, last_sess_r, last_seq_r + SEQ_ONE,
                   {$urandom, $urandom}, SELECT_BITS'($urandom_range(0, 7)));
    if (!prior_r) begin
      it.sess = jump;
      it.seq = SEQ_ONE;
    end else if ($urandom_range(0, 7) == 0 && ~last_sess_r >= jump) begin
      it.sess = last_sess_r + jump;
      it.seq = SEQ_ONE;
    end
    return it;
  endfunction

  task automatic test_status_and_empty_commit();
    send_item(make_item(MODE_STATUS, 1'b1, '1, '1, '1, SEL_UNUSED));
    send_item(make_item(MODE_COMMIT, 1'b1, 64'd1, SEQ_ONE, '0, CNT_COMMITTED));
  endtask

  task automatic test_enqueue_rules();
    send_item(make_item(MODE_ENQUEUE, 1'b0, '0, SEQ_ONE, '1, CNT_INVALID));
    send_item(make_item(MODE_ENQUEUE, 1'b1, '0, 32'd2, '0, CNT_ORDER));
    // first record ever, session zero
    send_item(make_item(MODE_ENQUEUE, 1'b1, '0, SEQ_ONE, '0, CNT_ACCEPTED));
    send_item(make_item(MODE_ENQUEUE, 1'b1, '0, SEQ_ONE, '1, CNT_DUPLICATE));
    send_item(make_item(MODE_ENQUEUE, 1'b1, '0, '0, '1, CNT_ORDER));
    send_item(make_item(MODE_ENQUEUE, 1'b1, '0, 32'd2, '1, CNT_ACCEPTED));
    send_item(make_item(MODE_ENQUEUE, 1'b1, 64'd5, 32'd2, '0, CNT_ORDER));
    send_item(make_item(MODE_ENQUEUE, 1'b1, 64'd5, SEQ_ONE, 64'h0123_4567_89ab_cdef,
                        CNT_ACCEPTED));
  endtask

  task automatic test_full_and_discard();
    for (int s = 2; s <= 15; s++)
      send_item(make_item(MODE_ENQUEUE, 1'b1, 64'd5, s, {$urandom, $urandom},
                          (s == 15) ? CNT_FULL : CNT_ACCEPTED));
    // front has session zero, which a commit can never match
    send_item(make_item(MODE_COMMIT, 1'b1, '0, SEQ_ONE, '0, CNT_COMMITTED));
    send_item(make_item(MODE_COMMIT, 1'b1, 64'd5, 32'd3, '0, CNT_COMMITTED));
    send_item(make_item(MODE_DISCARD, 1'b0, '0, '0, '0, CNT_DISCARDED));
  endtask

  task automatic test_random_traffic();
    record_item_t it;
    int r;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = ((i / 200) % 4) == 3;
      if (i == RANDOM_ITEMS / 2) wait_for_drain();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        it = next_record();
      end else if (r < 68) begin
        it = make_item(MODE_COMMIT, 1'($urandom_range(0, 1)), {$urandom, $urandom}, $urandom,
                       {$urandom, $urandom}, SELECT_BITS'($urandom_range(0, 7)));
        if (fill_r != 0 && $urandom_range(0, 7) != 0) begin
          it.sess = ring_sess[head_r];
          it.seq = ring_seq[head_r];
        end else if (fill_r != 0 && $urandom_range(0, 1) == 0) begin
          it.sess = ring_sess[head_r];
        end
      end else if (r < 72) begin
        it = make_item(MODE_DISCARD, 1'($urandom_range(0, 1)), {$urandom, $urandom}, $urandom,
                       {$urandom, $urandom}, SELECT_BITS'($urandom_range(0, 7)));
      end else if (r < 82) begin
        it = make_item(MODE_STATUS, 1'($urandom_range(0, 1)), {$urandom, $urandom}, $urandom,
                       {$urandom, $urandom}, SELECT_BITS'($urandom_range(0, 7)));
      end else begin
        it = next_record();
        case ($urandom_range(0, 2))
          0: begin
            it.sess = last_sess_r;
            it.seq = last_seq_r;
          end
          1: it.ok = 1'b0;
          default: begin
            it.ok = 1'($urandom_range(0, 1));
            it.sess = {$urandom, $urandom};
            it.seq = $urandom;
          end
        endcase
      end
      send_item(it);
    end
    quiet = 1'b0;
  endtask

  task automatic test_session_ceiling();
    wait_for_drain();
    send_item(make_item(MODE_DISCARD, 1'b1, '0, '0, '0, CNT_DISCARDED));
    send_item(make_item(MODE_ENQUEUE, 1'b1, '1, SEQ_ONE, '1, CNT_ACCEPTED));
    send_item(make_item(MODE_ENQUEUE, 1'b1, '1, 32'd2, {$urandom, $urandom}, CNT_ORDER));
    send_item(make_item(MODE_COMMIT, 1'b1, '1, SEQ_ONE, '0, CNT_COMMITTED));
    send_item(make_item(MODE_STATUS, 1'b0, '0, '0, '0, CNT_DUPLICATE));
  endtask

  initial begin
    for (int k = 0; k < NUM_COUNTERS; k++) event_cnt[k] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_status_and_empty_commit();
    test_enqueue_rules();
    test_full_and_discard();
    test_random_traffic();
    test_session_ceiling();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sequence_checked_record_outbox.f]
sv/scro_pkg.sv
sv/scro_ctrl.sv
sv/scro_datapath.sv
sv/sequence_checked_record_outbox.sv
tb/sv/sequence_checked_record_outbox_tb.sv
